FILE: hw/rtl/tlsc_pkg.sv
package tlsc_pkg;

   localparam int WINDOW_CHARS = 10;
   localparam int GAP_CHARS    = 3;
   localparam int STORE_DEPTH  = 64;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_CHARS + 1);
   localparam int LEN_W  = 6;
   localparam int POS_W  = 7;

   localparam logic [7:0] SPACE_CODE = 8'd32;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [5:0] char_index;
      logic [7:0] char_value;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last_char;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

endpackage

FILE: hw/rtl/text_line_scroll_or_centre.sv
// A write word is stored when accepted. A render word is accepted only in the idle state;
// its first character passes the read stage into the output register. Characters then
// leave at one per cycle while rsp_ready is high, so the next word after a render is
// accepted once its last character is issued; only non-space characters read the store.
// Synchronous reset clears the length, scroll phase, state, count and valid flags only;
// the text store is not cleared and reads of unwritten entries are undefined.
module text_line_scroll_or_centre (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tlsc_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tlsc_pkg::rsp_type     rsp_data,
   input  logic                  csr_wr_en,
   input  logic [5:0]            csr_wr_data
);
   import tlsc_pkg::*;

   logic [7:0] text_store [STORE_DEPTH];
   logic [7:0] mem_q_ff;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff;
   logic [POS_W-1:0]  phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  num_ff, num_in;
   logic [CNT_W-1:0]  pad_ff, pad_in;
   logic              scroll_ff, scroll_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_space_ff, s1_space_in;
   logic              s1_last_ff, s1_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [POS_W-1:0]  cycle_len;
   logic [POS_W-1:0]  phase_inc;
   logic [POS_W-1:0]  pos_inc;
   logic [POS_W-1:0]  pad_len;
   logic              accept;
   logic              advance1;
   logic              issue;
   logic              in_pad;
   logic              cur_space;
   logic              cur_last;
   logic              mem_rd;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_wr;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cycle_len = POS_W'(len_ff) + POS_W'(GAP_CHARS);
   assign phase_inc = (phase_ff + 1'b1 == cycle_len) ? '0 : phase_ff + 1'b1;
   assign pos_inc   = (pos_ff + 1'b1 == cycle_len) ? '0 : pos_ff + 1'b1;
   assign pad_len   = (POS_W'(WINDOW_CHARS) - POS_W'(len_ff)) >> 1;

   assign advance1 = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign issue    = (state_ff == ST_RUN) && (!s1_valid_ff || advance1);
   assign in_pad   = !scroll_ff && (cnt_ff < pad_ff);
   assign cur_space = in_pad || (pos_ff >= POS_W'(len_ff))
                      || (32'(pos_ff) >= STORE_DEPTH);
   assign cur_last  = (cnt_ff == num_ff - 1'b1);
   assign mem_rd    = issue && !cur_space;
   assign rd_addr   = ADDR_W'(pos_ff);
   assign mem_wr    = accept && (req_data.opcode == OP_WRITE)
                      && (32'(req_data.char_index) < STORE_DEPTH);

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      num_in      = num_ff;
      pad_in      = pad_ff;
      scroll_in   = scroll_ff;
      s1_valid_in = s1_valid_ff;
      s1_space_in = s1_space_ff;
      s1_last_in  = s1_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance1) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.char_out  = s1_space_ff ? SPACE_CODE : mem_q_ff;
         rsp_data_in.last_char = s1_last_ff;
         s1_valid_in           = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.opcode == OP_RENDER)) begin
               cnt_in = '0;
               if (32'(len_ff) > WINDOW_CHARS) begin
                  scroll_in = 1'b1;
                  phase_in  = phase_inc;
                  pos_in    = phase_inc;
                  num_in    = CNT_W'(WINDOW_CHARS);
                  pad_in    = '0;
                  state_in  = ST_RUN;
               end else begin
                  scroll_in = 1'b0;
                  pos_in    = '0;
                  pad_in    = CNT_W'(pad_len);
                  num_in    = CNT_W'(pad_len + POS_W'(len_ff));
                  if ((pad_len + POS_W'(len_ff)) != '0) begin
                     state_in = ST_RUN;
                  end
               end
            end
         end
         ST_RUN: begin
            if (issue) begin
               s1_valid_in = 1'b1;
               s1_space_in = cur_space;
               s1_last_in  = cur_last;
               cnt_in      = cnt_ff + 1'b1;
               if (scroll_ff) begin
                  pos_in = pos_inc;
               end else if (!in_pad) begin
                  pos_in = pos_ff + 1'b1;
               end
               if (cur_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         phase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         text_store[ADDR_W'(req_data.char_index)] <= req_data.char_value;
      end
      if (mem_rd) begin
         mem_q_ff <= text_store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         phase_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      num_ff      <= num_in;
      pad_ff      <= pad_in;
      scroll_ff   <= scroll_in;
      s1_space_ff <= s1_space_in;
      s1_last_ff  <= s1_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register is not one-hot");

   a_count_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cnt_ff < num_ff))
      else $error("character count has run past the frame");

   a_phase_in_cycle: assert property (@(posedge clock) disable iff (reset)
      (32'(len_ff) > WINDOW_CHARS) |-> (phase_ff < cycle_len))
      else $error("scroll phase outside its cycle");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance1) |=> (s1_valid_ff && $stable(mem_q_ff)))
      else $error("stalled read stage lost its word");

endmodule
